/* sv/latan_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latan_pkg: shared types and tables for the 8-bit vector angle unit.
// Holds the log2 table, the arctangent table and the octant masks.
// ----------------------------------------------------------------------------
package latan_pkg;

  localparam int DeltaWidth = 9;
  localparam int AngleWidth = 8;

  typedef logic signed [DeltaWidth-1:0] delta_t;
  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef logic [7:0] byte_t;

  localparam angle_t ANGLE_POS_X = 8'sh00;
  localparam angle_t ANGLE_POS_Y = 8'sh40;
  localparam angle_t ANGLE_NEG_Y = 8'shC0;
  localparam angle_t ANGLE_NEG_X = 8'sh80;

  // Indexed by {x negative, y negative, log of x at least log of y}.
  localparam byte_t OCTANT_MASK [8] = '{
    8'h3F, 8'h00, 8'hC0, 8'hFF, 8'h40, 8'h7F, 8'hBF, 8'h80
  };

  // Thirty-two times log2 of the index.
  localparam byte_t LOG2_ROM [256] = '{
    8'h00,8'h00,8'h20,8'h32,8'h40,8'h4a,8'h52,8'h59,8'h60,8'h65,8'h6a,8'h6e,8'h72,8'h76,8'h79,8'h7d,
    8'h80,8'h82,8'h85,8'h87,8'h8a,8'h8c,8'h8e,8'h90,8'h92,8'h94,8'h96,8'h98,8'h99,8'h9b,8'h9d,8'h9e,
    8'ha0,8'ha1,8'ha2,8'ha4,8'ha5,8'ha6,8'ha7,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,
    8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbd,8'hbe,8'hbf,
    8'hc0,8'hc0,8'hc1,8'hc2,8'hc2,8'hc3,8'hc4,8'hc4,8'hc5,8'hc6,8'hc6,8'hc7,8'hc7,8'hc8,8'hc9,8'hc9,
    8'hca,8'hca,8'hcb,8'hcc,8'hcc,8'hcd,8'hcd,8'hce,8'hce,8'hcf,8'hcf,8'hd0,8'hd0,8'hd1,8'hd1,8'hd2,
    8'hd2,8'hd3,8'hd3,8'hd4,8'hd4,8'hd5,8'hd5,8'hd5,8'hd6,8'hd6,8'hd7,8'hd7,8'hd8,8'hd8,8'hd9,8'hd9,
    8'hd9,8'hda,8'hda,8'hdb,8'hdb,8'hdb,8'hdc,8'hdc,8'hdd,8'hdd,8'hdd,8'hde,8'hde,8'hde,8'hdf,8'hdf,
    8'hdf,8'he0,8'he0,8'he1,8'he1,8'he1,8'he2,8'he2,8'he2,8'he3,8'he3,8'he3,8'he4,8'he4,8'he4,8'he5,
    8'he5,8'he5,8'he6,8'he6,8'he6,8'he7,8'he7,8'he7,8'he7,8'he8,8'he8,8'he8,8'he9,8'he9,8'he9,8'hea,
    8'hea,8'hea,8'hea,8'heb,8'heb,8'heb,8'hec,8'hec,8'hec,8'hec,8'hed,8'hed,8'hed,8'hed,8'hee,8'hee,
    8'hee,8'hee,8'hef,8'hef,8'hef,8'hef,8'hf0,8'hf0,8'hf0,8'hf1,8'hf1,8'hf1,8'hf1,8'hf1,8'hf2,8'hf2,
    8'hf2,8'hf2,8'hf3,8'hf3,8'hf3,8'hf3,8'hf4,8'hf4,8'hf4,8'hf4,8'hf5,8'hf5,8'hf5,8'hf5,8'hf5,8'hf6,
    8'hf6,8'hf6,8'hf6,8'hf7,8'hf7,8'hf7,8'hf7,8'hf7,8'hf8,8'hf8,8'hf8,8'hf8,8'hf9,8'hf9,8'hf9,8'hf9,
    8'hf9,8'hfa,8'hfa,8'hfa,8'hfa,8'hfa,8'hfb,8'hfb,8'hfb,8'hfb,8'hfb,8'hfc,8'hfc,8'hfc,8'hfc,8'hfc,
    8'hfd,8'hfd,8'hfd,8'hfd,8'hfd,8'hfd,8'hfe,8'hfe,8'hfe,8'hfe,8'hfe,8'hff,8'hff,8'hff,8'hff,8'hff
  };

  // Arctangent indexed by the log difference.
  localparam byte_t ATAN_ROM [256] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,
    8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,
    8'h03,8'h03,8'h03,8'h03,8'h03,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,
    8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h06,8'h06,8'h06,8'h06,8'h06,8'h06,8'h06,8'h06,
    8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h09,8'h09,8'h09,8'h09,
    8'h09,8'h0a,8'h0a,8'h0a,8'h0a,8'h0b,8'h0b,8'h0b,8'h0b,8'h0c,8'h0c,8'h0c,8'h0c,8'h0d,8'h0d,8'h0d,
    8'h0d,8'h0e,8'h0e,8'h0e,8'h0e,8'h0f,8'h0f,8'h0f,8'h10,8'h10,8'h10,8'h11,8'h11,8'h11,8'h12,8'h12,
    8'h12,8'h13,8'h13,8'h13,8'h14,8'h14,8'h15,8'h15,8'h15,8'h16,8'h16,8'h17,8'h17,8'h17,8'h18,8'h18,
    8'h19,8'h19,8'h19,8'h1a,8'h1a,8'h1b,8'h1b,8'h1c,8'h1c,8'h1c,8'h1d,8'h1d,8'h1e,8'h1e,8'h1f,8'h1f
  };

endpackage

/* sv/log_table_atan2_8bit.sv */
`timescale 1ns / 1ps
// An accepted item goes through the input register and then the result
// register to angle. Throughput: one item per cycle while the result side is
// free; the two registers form a two-stage pipeline that stalls otherwise.
// Reset clears both stage valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
// log_table_atan2_8bit: vector angle from log2 and arctangent tables.
// Returns the angle of (delta_x, delta_y) with 256 units per full turn.
// ----------------------------------------------------------------------------
module log_table_atan2_8bit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    delta_valid,
  output logic                    delta_ready,
  input  latan_pkg::delta_t       delta_x,
  input  latan_pkg::delta_t       delta_y,
  output logic                    angle_valid,
  input  logic                    angle_ready,
  output latan_pkg::angle_t       angle
);

  logic              s1_valid;
  latan_pkg::delta_t s1_dx;
  latan_pkg::delta_t s1_dy;
  logic              s2_ready;

  logic [8:0]        mag_x;
  logic [8:0]        mag_y;
  logic              big;
  logic [7:0]        half_x;
  logic [7:0]        half_y;
  logic              neg_x;
  logic              neg_y;
  latan_pkg::byte_t  log_x;
  latan_pkg::byte_t  log_y;
  latan_pkg::byte_t  diff;
  logic              x_ge;
  latan_pkg::byte_t  idx;
  logic [2:0]        oct;
  latan_pkg::angle_t angle_next;

  assign s2_ready    = !angle_valid || angle_ready;
  assign delta_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (delta_ready) begin
      s1_valid <= delta_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (delta_ready && delta_valid) begin
      s1_dx <= delta_x;
      s1_dy <= delta_y;
    end
  end

  always_comb begin
    mag_x  = s1_dx[8] ? (~s1_dx + 9'd1) : s1_dx;
    mag_y  = s1_dy[8] ? (~s1_dy + 9'd1) : s1_dy;
    big    = mag_x[8] | mag_x[7] | mag_y[8] | mag_y[7];
    half_x = big ? mag_x[8:1] : mag_x[7:0];
    half_y = big ? mag_y[8:1] : mag_y[7:0];
    neg_x  = s1_dx[8] && (half_x != 8'd0);
    neg_y  = s1_dy[8] && (half_y != 8'd0);
    log_x  = latan_pkg::LOG2_ROM[half_x];
    log_y  = latan_pkg::LOG2_ROM[half_y];
    diff   = log_x - log_y;
    x_ge   = log_x >= log_y;
    idx    = x_ge ? ~diff : diff;
    oct    = {neg_x, neg_y, x_ge};
    if (s1_dx == 9'sd0) begin
      angle_next = (s1_dy > 9'sd0) ? latan_pkg::ANGLE_POS_Y : latan_pkg::ANGLE_NEG_Y;
    end else if (s1_dy == 9'sd0) begin
      angle_next = (s1_dx > 9'sd0) ? latan_pkg::ANGLE_POS_X : latan_pkg::ANGLE_NEG_X;
    end else begin
      angle_next = latan_pkg::angle_t'(latan_pkg::ATAN_ROM[idx]
                                        ^ latan_pkg::OCTANT_MASK[oct]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (s2_ready) begin
      angle_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      angle <= angle_next;
    end
  end

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    delta_valid && delta_ready |=> s1_valid)
    else $error("Accepted item did not reach the input register.");

  a_s1_moves_on : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> angle_valid)
    else $error("Registered item did not reach the result register.");

  a_vertical_axis : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && (s1_dx == 9'sd0)
      |=> (angle == latan_pkg::ANGLE_POS_Y) || (angle == latan_pkg::ANGLE_NEG_Y))
    else $error("Vector on the vertical axis gave a wrong angle.");

  a_stall_holds_s1 : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_dx) && $stable(s1_dy))
    else $error("Input register changed while the result side stalled.");

endmodule
